// ===== design/arp_pkg.sv =====
// Shared types and constants for the ARM relocation patcher.
`default_nettype none
package arp_pkg;

	// ARM ELF relocation type numbers handled by the block.
	localparam logic [7:0] RT_ABS32           = 8'd2;
	localparam logic [7:0] RT_REL32           = 8'd3;
	localparam logic [7:0] RT_THM_CALL        = 8'd10;
	localparam logic [7:0] RT_CALL            = 8'd28;
	localparam logic [7:0] RT_JUMP24          = 8'd29;
	localparam logic [7:0] RT_TARGET1         = 8'd38;
	localparam logic [7:0] RT_V4BX            = 8'd40;
	localparam logic [7:0] RT_TARGET2         = 8'd41;
	localparam logic [7:0] RT_PREL31          = 8'd42;
	localparam logic [7:0] RT_MOVW_ABS_NC     = 8'd43;
	localparam logic [7:0] RT_MOVT_ABS        = 8'd44;
	localparam logic [7:0] RT_THM_MOVW_ABS_NC = 8'd47;
	localparam logic [7:0] RT_THM_MOVT_ABS    = 8'd48;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_SKIP     = 2'd3;

	// Depth of each of the two internal queues.
	localparam int unsigned QDepth = 2;

	typedef enum logic [3:0] {
		OP_SKIP,
		OP_V4BX,
		OP_ABS,
		OP_REL,
		OP_THM_CALL,
		OP_CALL,
		OP_PREL31,
		OP_MOVW,
		OP_MOVT,
		OP_THM_MOVW,
		OP_THM_MOVT
	} op_t;

	typedef struct packed {
		logic [7:0]  func;
		logic [31:0] sym_base;
		logic [31:0] data_base;
		logic [31:0] data_offset;
		logic [31:0] data_size;
		logic [31:0] addend;
		logic [31:0] old_word;
	} reloc_t;

	typedef struct packed {
		logic [31:0] new_word;
		logic [31:0] write_address;
		logic        write_enable;
		logic [1:0]  status;
	} patch_t;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		op_t         op;
		logic [31:0] place;
		logic [31:0] absv;
		logic [31:0] old_word;
		logic        ovf;
	} mid_t;

endpackage
`default_nettype wire

// ===== design/arp_front.sv =====
// Front part: accepts relocations, decodes the type and queues the classified item.
`default_nettype none
module arp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire arp_pkg::reloc_t reloc,
	output logic                mid_empty,
	output arp_pkg::mid_t       mid_head,
	input  wire logic           take
);
	import arp_pkg::*;

	mid_t       mem_q [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	mid_t       cls;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		unique case (reloc.func)
			RT_V4BX:                         cls.op = OP_V4BX;
			RT_ABS32, RT_TARGET1:            cls.op = OP_ABS;
			RT_REL32, RT_TARGET2:            cls.op = OP_REL;
			RT_THM_CALL:                     cls.op = OP_THM_CALL;
			RT_CALL, RT_JUMP24:              cls.op = OP_CALL;
			RT_PREL31:                       cls.op = OP_PREL31;
			RT_MOVW_ABS_NC:                  cls.op = OP_MOVW;
			RT_MOVT_ABS:                     cls.op = OP_MOVT;
			RT_THM_MOVW_ABS_NC:              cls.op = OP_THM_MOVW;
			RT_THM_MOVT_ABS:                 cls.op = OP_THM_MOVT;
			default:                         cls.op = OP_SKIP;
		endcase
		cls.place    = reloc.data_base + reloc.data_offset;
		cls.absv     = reloc.sym_base + reloc.addend;
		cls.old_word = reloc.old_word;
		// The segment check is done one bit wider so that it cannot wrap.
		cls.ovf      = ({1'b0, reloc.data_offset} + 33'd4) > {1'b0, reloc.data_size};
	end

	assign full      = (cnt_q == 2'(QDepth));
	assign mid_empty = (cnt_q == 2'd0);
	assign mid_head  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = take && !mid_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth))
		else $error("front queue count above its depth");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !mid_empty)
		else $error("accepted item missing from front queue");

endmodule
`default_nettype wire

// ===== design/arp_back.sv =====
// Back part: computes the patched word and status and queues the result.
`default_nettype none
module arp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mid_empty,
	input  wire arp_pkg::mid_t mid_head,
	output logic               take,
	output logic               empty,
	input  wire logic          pop,
	output arp_pkg::patch_t    patch
);
	import arp_pkg::*;

	patch_t      mem_q [QDepth];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	patch_t      res;
	logic [31:0] rel;
	logic [31:0] thm_chk;
	logic [31:0] arm_chk;
	logic [31:0] word;
	logic        range_err;
	logic        rq_full;
	logic        do_pop;

	function automatic logic [31:0] thumb_call(input logic [31:0] old, input logic [31:0] off);
		logic s;
		logic j1;
		logic j2;
		s  = off[24];
		j1 = s ^ ~off[23];
		j2 = s ^ ~off[22];
		return {old[31:30], j1, old[28], j2, off[11:1], old[15:11], s, off[21:12]};
	endfunction

	function automatic logic [31:0] thumb_mov(input logic [31:0] old, input logic [15:0] imm);
		return {old[31], imm[10:8], old[27:24], imm[7:0],
			old[15:11], imm[11], old[9:4], imm[15:12]};
	endfunction

	function automatic logic [31:0] arm_mov(input logic [31:0] old, input logic [15:0] imm);
		return {old[31:20], imm[15:12], old[15:12], imm[11:0]};
	endfunction

	always_comb begin
		rel       = mid_head.absv - mid_head.place;
		// Offset is in range when it lies strictly inside the signed branch window.
		thm_chk   = rel + 32'h00ff_ffff;
		arm_chk   = rel + 32'h01ff_ffff;
		range_err = 1'b0;
		word      = 32'd0;
		unique case (mid_head.op)
			OP_V4BX:     word = {mid_head.old_word[31:28], 24'h1a_0f00, mid_head.old_word[3:0]};
			OP_ABS:      word = mid_head.absv;
			OP_REL:      word = rel;
			OP_THM_CALL: begin
				range_err = (thm_chk >= 32'h01ff_ffff);
				word      = thumb_call(mid_head.old_word, rel);
			end
			OP_CALL: begin
				range_err = (arm_chk >= 32'h03ff_ffff);
				word      = {mid_head.old_word[31:24], rel[25:2]};
			end
			OP_PREL31:   word = {1'b0, rel[30:0]};
			OP_MOVW:     word = arm_mov(mid_head.old_word, mid_head.absv[15:0]);
			OP_MOVT:     word = arm_mov(mid_head.old_word, mid_head.absv[31:16]);
			OP_THM_MOVW: word = thumb_mov(mid_head.old_word, mid_head.absv[15:0]);
			OP_THM_MOVT: word = thumb_mov(mid_head.old_word, mid_head.absv[31:16]);
			OP_SKIP:     word = 32'd0;
			default:     word = 32'd0;
		endcase

		priority if (mid_head.op == OP_SKIP) begin
			res.status = ST_SKIP;
		end else if (range_err) begin
			res.status = ST_RANGE;
		end else if (mid_head.ovf) begin
			res.status = ST_OVERFLOW;
		end else begin
			res.status = ST_OK;
		end
		res.write_enable  = (res.status == ST_OK);
		res.new_word      = res.write_enable ? word : 32'd0;
		res.write_address = mid_head.place;
	end

	assign rq_full = (cnt_q == 2'(QDepth));
	assign take    = !mid_empty && !rq_full;
	assign empty   = (cnt_q == 2'd0);
	assign patch   = mem_q[rd_ptr_q];
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (take) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (take) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(take) - 2'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth))
		else $error("result queue count above its depth");
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !empty)
		else $error("computed result missing from result queue");
	a_strobe_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && patch.write_enable |-> patch.status == ST_OK)
		else $error("write strobe with a failing status");
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !patch.write_enable |-> patch.new_word == 32'd0)
		else $error("suppressed write carries a non-zero word");

endmodule
`default_nettype wire

// ===== design/arm_relocation_patcher.sv =====
// Top level of the ARM relocation patcher: front and back parts joined by a queue.
// One decoded relocation is taken per push and gives exactly one result item,
// in order. The block sustains one item per clock cycle while the result side is
// not stalled: the front part decodes the type, forms the place and absolute value
// and checks the segment bound into a two-entry queue, and the back part takes the
// head of that queue, forms the relative value, checks branch range and merges the
// word into a two-entry result queue, from which the result is popped.
// Either queue absorbs a short stall on its own side; full rises only once the
// front queue holds two items, which needs a stall on the result side first.
// A result with a non-zero status has write_enable low and new_word zero;
// write_address is always given.
`default_nettype none
module arm_relocation_patcher (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire arp_pkg::reloc_t reloc,
	output logic                 empty,
	input  wire logic            pop,
	output arp_pkg::patch_t      patch
);
	import arp_pkg::*;

	logic mid_empty;
	mid_t mid_head;
	logic take;

	arp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.reloc     (reloc),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.take      (take)
	);

	arp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.take      (take),
		.empty     (empty),
		.pop       (pop),
		.patch     (patch)
	);

endmodule
`default_nettype wire

// ===== bench/arm_relocation_patcher_tb.sv =====
// Self-checking testbench for the ARM relocation patcher: directed table, then random phases.
`timescale 1ns / 1ps

module arm_relocation_patcher_tb;
	import arp_pkg::*;

	localparam logic [7:0] RT_NONE      = 8'd0;
	localparam logic [7:0] UNKNOWN_TYPE = 8'd255;
	localparam int RANDOM_PER_PHASE     = 340;
	localparam int STALL_LIMIT          = 2000;
	localparam int TAIL_CYCLES          = 8;
	localparam int REPORT_LIMIT         = 10;

	typedef struct {
		reloc_t item;
		bit     typed;
		patch_t want;
	} vector_t;

	logic   clk;
	logic   arst_n;
	logic   push;
	logic   full;
	reloc_t reloc;
	logic   empty;
	logic   pop;
	patch_t patch;

	patch_t  pending_patches[$];
	patch_t  next_expected;
	vector_t directed_rows[$];
	int      fault_count = 0;
	int      quiet_cycles = 0;
	int      send_idle = 0;
	int      pop_stall = 0;

	arm_relocation_patcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.reloc(reloc),
		.empty(empty),
		.pop(pop),
		.patch(patch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Works out the patch that one relocation must give.
	function automatic patch_t predict_patch(reloc_t r);
		logic [31:0] place, absv, rel, bias, word;
		logic [15:0] hw1, hw2, imm;
		logic [1:0]  st;
		patch_t      p;
		place = r.data_base + r.data_offset;
		absv = r.sym_base + r.addend;
		rel = absv - place;
		hw1 = r.old_word[15:0];
		hw2 = r.old_word[31:16];
		word = '0;
		st = ST_OK;
		case (r.func)
			RT_V4BX: word = (r.old_word & 32'hf000000f) | 32'h01a0f000;
			RT_ABS32, RT_TARGET1: word = absv;
			RT_REL32, RT_TARGET2: word = rel;
			RT_THM_CALL: begin
				bias = rel + 32'h00ffffff;
				if (bias >= 32'h01ffffff)
					st = ST_RANGE;
				else
					word = {hw2[15:14], rel[24] ^ ~rel[23], hw2[12], rel[24] ^ ~rel[22],
						rel[11:1], hw1[15:11], rel[24], rel[21:12]};
			end
			RT_CALL, RT_JUMP24: begin
				bias = rel + 32'h01ffffff;
				if (bias >= 32'h03ffffff)
					st = ST_RANGE;
				else
					word = {r.old_word[31:24], rel[25:2]};
			end
			RT_PREL31: word = {1'b0, rel[30:0]};
			RT_MOVW_ABS_NC, RT_MOVT_ABS: begin
				imm = (r.func == RT_MOVT_ABS) ? absv[31:16] : absv[15:0];
				word = {r.old_word[31:20], imm[15:12], r.old_word[15:12], imm[11:0]};
			end
			RT_THM_MOVW_ABS_NC, RT_THM_MOVT_ABS: begin
				imm = (r.func == RT_THM_MOVT_ABS) ? absv[31:16] : absv[15:0];
				word = {hw2[15], imm[10:8], hw2[11:8], imm[7:0],
					hw1[15:11], imm[11], hw1[9:4], imm[15:12]};
			end
			default: st = ST_SKIP;
		endcase
		// The segment bound is checked without wrap-around.
		if (st == ST_OK && ({1'b0, r.data_offset} + 33'd4 > {1'b0, r.data_size}))
			st = ST_OVERFLOW;
		if (st != ST_OK)
			word = '0;
		p.new_word = word;
		p.write_address = place;
		p.write_enable = (st == ST_OK);
		p.status = st;
		return p;
	endfunction

	function automatic reloc_t reloc_of(logic [7:0] func, logic [31:0] sym, logic [31:0] base,
			logic [31:0] offs, logic [31:0] size, logic [31:0] add, logic [31:0] old);
		reloc_t r;
		r.func = func;
		r.sym_base = sym;
		r.data_base = base;
		r.data_offset = offs;
		r.data_size = size;
		r.addend = add;
		r.old_word = old;
		return r;
	endfunction

	function automatic patch_t result_of(logic [31:0] word, logic [31:0] addr, logic [1:0] st);
		patch_t p;
		p.new_word = word;
		p.write_address = addr;
		p.write_enable = (st == ST_OK);
		p.status = st;
		return p;
	endfunction

	function automatic void add_row(reloc_t item, bit typed, patch_t want);
		vector_t v;
		v.item = item;
		v.typed = typed;
		v.want = want;
		directed_rows.push_back(v);
	endfunction

	function automatic reloc_t random_reloc();
		reloc_t      r;
		logic [31:0] place, rel, lim;
		if ($urandom_range(0, 9) == 0)
			r.func = 8'($urandom_range(0, 255));
		else begin
			case ($urandom_range(0, 13))
				0: r.func = RT_NONE;
				1: r.func = RT_ABS32;
				2: r.func = RT_REL32;
				3: r.func = RT_THM_CALL;
				4: r.func = RT_CALL;
				5: r.func = RT_JUMP24;
				6: r.func = RT_TARGET1;
				7: r.func = RT_V4BX;
				8: r.func = RT_TARGET2;
				9: r.func = RT_PREL31;
				10: r.func = RT_MOVW_ABS_NC;
				11: r.func = RT_MOVT_ABS;
				12: r.func = RT_THM_MOVW_ABS_NC;
				default: r.func = RT_THM_MOVT_ABS;
			endcase
		end
		r.sym_base = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom();
		r.data_base = $urandom();
		r.data_offset = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 4095) : $urandom();
		// Mostly a segment that holds the word, often with no room to spare.
		if (r.data_offset <= 32'hfffffffb && $urandom_range(0, 99) < 75) begin
			if ($urandom_range(0, 3) == 0)
				r.data_size = r.data_offset + 32'd4;
			else
				r.data_size = $urandom_range(32'hffffffff, r.data_offset + 32'd4);
		end else
			r.data_size = $urandom();
		r.addend = $urandom();
		r.old_word = $urandom();
		// Steer most branches to a chosen offset so that the in-range path is well exercised.
		if ((r.func == RT_THM_CALL || r.func == RT_CALL || r.func == RT_JUMP24)
				&& $urandom_range(0, 9) < 7) begin
			lim = (r.func == RT_THM_CALL) ? 32'h01000000 : 32'h02000000;
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: rel = lim - 32'd1;
					1: rel = lim;
					2: rel = -lim;
					default: rel = 32'd1 - lim;
				endcase
			end else
				rel = $urandom_range(0, 2 * lim - 2) - (lim - 32'd1);
			place = r.data_base + r.data_offset;
			r.addend = rel + place - r.sym_base;
		end
		return r;
	endfunction

	task automatic offer_reloc(input reloc_t item, input patch_t want);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		reloc <= item;
		next_expected = want;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_patches();
		push <= 1'b0;
		while (pending_patches.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		pop <= ($urandom_range(0, 99) >= pop_stall);
	end

	always @(posedge clk) begin
		patch_t want;
		if (arst_n) begin
			if (push && !full)
				pending_patches.push_back(next_expected);
			if (pop && !empty) begin
				if (pending_patches.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("unexpected item: word %h addr %h we %b status %0d",
							patch.new_word, patch.write_address, patch.write_enable, patch.status);
				end else begin
					want = pending_patches.pop_front();
					if (patch.new_word !== want.new_word
							|| patch.write_address !== want.write_address
							|| patch.write_enable !== want.write_enable
							|| patch.status !== want.status) begin
						fault_count++;
						if (fault_count <= REPORT_LIMIT)
							$display("mismatch: expected word %h addr %h we %b status %0d, got word %h addr %h we %b status %0d",
								want.new_word, want.write_address, want.write_enable, want.status,
								patch.new_word, patch.write_address, patch.write_enable,
								patch.status);
					end
				end
			end
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		reloc_t item;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		reloc = '0;
		next_expected = '0;

		// Rows with a typed result can be read straight off the rules; the rest are predicted.
		add_row(reloc_of(RT_NONE, 32'h12345678, 32'h00001000, 32'h10, 32'h100, 32'h9, 32'hdeadbeef),
			1, result_of(32'h0, 32'h00001010, ST_SKIP));
		add_row(reloc_of(UNKNOWN_TYPE, '1, '1, '1, '1, '1, '1),
			1, result_of(32'h0, 32'hfffffffe, ST_SKIP));
		add_row(reloc_of(RT_ABS32, 32'hffffffff, 32'h0, 32'h0, 32'h4, 32'h1, 32'hffffffff),
			1, result_of(32'h0, 32'h0, ST_OK));
		add_row(reloc_of(RT_ABS32, 32'h1000, 32'h8000, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0),
			1, result_of(32'h0, 32'h00007fff, ST_OVERFLOW));
		add_row(reloc_of(RT_ABS32, 32'h1000, 32'h8000, 32'h0, 32'h0, 32'h0, 32'h0),
			1, result_of(32'h0, 32'h00008000, ST_OVERFLOW));
		add_row(reloc_of(RT_ABS32, 32'h80000000, 32'h5, 32'hfffffffb, 32'hffffffff, 32'h7fffffff,
			32'h0), 1, result_of(32'hffffffff, 32'h0, ST_OK));
		add_row(reloc_of(RT_V4BX, 32'h0, 32'h100, 32'h4, 32'h8, 32'h0, 32'hffffffff),
			1, result_of(32'hf1a0f00f, 32'h00000104, ST_OK));
		add_row(reloc_of(RT_V4BX, 32'hffffffff, 32'h100, 32'h4, 32'h8, 32'hffffffff, 32'h0),
			1, result_of(32'h01a0f000, 32'h00000104, ST_OK));
		add_row(reloc_of(RT_REL32, 32'h2000, 32'h1000, 32'h0, 32'h10, 32'h0, 32'h0),
			1, result_of(32'h00001000, 32'h00001000, ST_OK));
		add_row(reloc_of(RT_TARGET1, 32'h89abcdef, 32'h40000000, 32'h20, 32'h40, 32'h76543210,
			32'h5a5a5a5a), 0, '0);
		add_row(reloc_of(RT_TARGET2, 32'h00000100, 32'h40000000, 32'h20, 32'h24, 32'h3, 32'ha5a5a5a5),
			0, '0);
		add_row(reloc_of(RT_THM_CALL, 32'h00ffffff, 32'h0, 32'h0, 32'h4, 32'h0, 32'hf800f000), 0, '0);
		add_row(reloc_of(RT_THM_CALL, 32'h01000000, 32'h0, 32'h0, 32'h4, 32'h0, 32'hf800f000),
			1, result_of(32'h0, 32'h0, ST_RANGE));
		add_row(reloc_of(RT_THM_CALL, 32'h0, 32'h01000000, 32'h0, 32'h4, 32'h0, 32'hf800f000),
			1, result_of(32'h0, 32'h01000000, ST_RANGE));
		add_row(reloc_of(RT_THM_CALL, 32'h1, 32'h01000000, 32'h0, 32'h4, 32'h0, 32'hffffffff), 0, '0);
		add_row(reloc_of(RT_CALL, 32'h02000000, 32'h0, 32'h0, 32'h4, 32'h0, 32'heb000000),
			1, result_of(32'h0, 32'h0, ST_RANGE));
		add_row(reloc_of(RT_JUMP24, 32'h0, 32'h02000000, 32'h0, 32'h4, 32'h0, 32'hea000000),
			1, result_of(32'h0, 32'h02000000, ST_RANGE));
		add_row(reloc_of(RT_CALL, 32'h01fffffc, 32'h0, 32'h0, 32'h4, 32'h0, 32'heb000000), 0, '0);
		add_row(reloc_of(RT_JUMP24, 32'h4, 32'h02000000, 32'h0, 32'h4, 32'h0, 32'hffffffff), 0, '0);
		// An out-of-range branch wins over a segment overflow.
		add_row(reloc_of(RT_CALL, 32'h7fffffff, 32'h0, 32'h100, 32'h0, 32'h0, 32'heb000000),
			1, result_of(32'h0, 32'h00000100, ST_RANGE));
		add_row(reloc_of(RT_PREL31, 32'h0, 32'h10, 32'h0, 32'h4, 32'h0, 32'hffffffff), 0, '0);
		add_row(reloc_of(RT_MOVW_ABS_NC, 32'hffffffff, 32'h0, 32'h0, 32'h4, 32'h0, 32'h0), 0, '0);
		add_row(reloc_of(RT_MOVT_ABS, 32'h12345678, 32'h0, 32'h0, 32'h4, 32'h0, 32'hffffffff), 0, '0);
		add_row(reloc_of(RT_THM_MOVW_ABS_NC, 32'hffffffff, 32'h0, 32'h0, 32'h4, 32'h0, 32'h0), 0, '0);
		add_row(reloc_of(RT_THM_MOVT_ABS, 32'habcd0000, 32'h0, 32'h0, 32'h4, 32'h0, 32'hffffffff),
			0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_reloc(directed_rows[i].item,
				directed_rows[i].typed ? directed_rows[i].want : predict_patch(directed_rows[i].item));
		drain_patches();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle = 0;
					pop_stall = 0;
				end
				1: begin
					send_idle = 45;
					pop_stall = 0;
				end
				2: begin
					send_idle = 0;
					pop_stall = 45;
				end
				default: begin
					send_idle = 15;
					pop_stall = 15;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				item = random_reloc();
				offer_reloc(item, predict_patch(item));
			end
			// Hold the sender back until every outstanding item has come out.
			drain_patches();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/arp_pkg.sv
design/arp_front.sv
design/arp_back.sv
design/arm_relocation_patcher.sv
bench/arm_relocation_patcher_tb.sv
